>>> rtl/enps_pkg.sv
// package for the earlier nearest point search block
// shared constants and status codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package enps_pkg;
	localparam int MAX_POINTS_DEF = 4096;
	localparam int COORD_BITS_DEF = 16;
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;
	localparam int DIST_W = 33;
	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_RANGE = 2'd1,
		ST_NONE = 2'd2
	} status_t;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

>>> rtl/earlier_nearest_point_search_top.sv
// top level of the earlier nearest point search block
// point memory, walk sequencer and output register; uses enps_pkg
//
//   channel | direction | handshake     | payload
//   in      | input     | in_valid/stall| operation, entry_index, coords, rank, colour
//   out     | output    | out_valid/stall| status, nearest_index/colour/sq_distance
//   cfg     | input     | cfg_we        | cfg_data (point_count)
// a load result is valid in the cycle after its transfer.
// a query reads the query entry (read, wait), then walks each entry (read, wait, compare) through
// the single read port, then finishes (done, copy; the copy is skipped when nothing is found).
// reset clears control and point_count; memory content is undefined until loaded.
// a waiting result holds in the output register; the next item is taken
// only once that register is free.
`timescale 1ns / 1ps
`default_nettype none
module earlier_nearest_point_search_top #(
	parameter int MAX_POINTS = enps_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = enps_pkg::COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [enps_pkg::CNT_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic operation,
	input  wire logic [enps_pkg::IDX_W-1:0] entry_index,
	input  wire logic [15:0] x_coord,
	input  wire logic [15:0] y_coord,
	input  wire logic [11:0] arrival_rank,
	input  wire logic [3:0] point_colour,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [1:0] status,
	output logic [enps_pkg::IDX_W-1:0] nearest_index,
	output logic [3:0] nearest_colour,
	output logic [enps_pkg::DIST_W-1:0] nearest_sq_distance
);
	import enps_pkg::*;
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int DW = 2 * COORD_BITS + 2;
	localparam int WW = 2 * COORD_BITS + 16;
	localparam logic [DW-1:0] INIT_BEST = DW'(2) << (2 * COORD_BITS);

	typedef enum logic [2:0] {S_IDLE, S_QRD, S_QLAT, S_CRD, S_CLAT, S_CMP, S_CPY, S_DONE}
		state_t;
	state_t state_q;

	logic [WW-1:0] mem [MAX_POINTS];
	logic [WW-1:0] rd_q;
	logic [AW-1:0] raddr;
	logic re;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W:0] cand_q;
	logic dir_q, found_q;
	logic [COORD_BITS-1:0] qx_q, qy_q;
	logic [11:0] qrank_q;
	logic [DW-1:0] best_q;
	logic [IDX_W-1:0] bidx_q;
	logic [COORD_BITS-1:0] cx, cy;
	logic [11:0] crank;
	logic [3:0] ccol;
	logic [COORD_BITS-1:0] ady, adx;
	logic [DW-1:0] sy_s1, sx_s1;
	logic ok_s1;
	logic [3:0] ccol_s1;
	logic [3:0] bcol_q;

	logic [CNT_W-1:0] ecount;
	assign ecount = (32'(count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : count_q;
	assign in_stall = (state_q != S_IDLE) || out_valid;
	wire take = in_valid && !in_stall;

	assign cx = rd_q[COORD_BITS+15:16];
	assign cy = rd_q[2*COORD_BITS+15:COORD_BITS+16];
	assign crank = rd_q[15:4];
	assign ccol = rd_q[3:0];
	assign adx = (qx_q >= cx) ? qx_q - cx : cx - qx_q;
	assign ady = (qy_q >= cy) ? qy_q - cy : cy - qy_q;

	// next candidate in current direction
	logic [IDX_W:0] nxt;
	logic nxt_ok;
	always_comb begin
		nxt = cand_q;
		nxt_ok = 1'b0;
		if (!dir_q) begin
			nxt_ok = cand_q != '0;
			nxt = cand_q - 1'b1;
		end else begin
			nxt = cand_q + 1'b1;
			nxt_ok = {1'b0, cand_q} + 14'd1 < {1'b0, ecount};
		end
	end
	wire [IDX_W:0] up_start = {1'b0, idx_q} + 1'b1;
	wire up_ok = {1'b0, up_start} < {1'b0, ecount};

	always_comb begin
		re = 1'b0;
		raddr = '0;
		case (state_q)
			S_QRD: begin re = 1'b1; raddr = idx_q[AW-1:0]; end
			S_CRD: begin re = 1'b1; raddr = cand_q[AW-1:0]; end
			default: ;
		endcase
	end

	wire [WW-1:0] load_word = {y_coord[COORD_BITS-1:0], x_coord[COORD_BITS-1:0],
		arrival_rank, point_colour};
	always_ff @(posedge clk) begin
		if (take && operation == OP_LOAD && 32'(entry_index) < MAX_POINTS)
			mem[entry_index[AW-1:0]] <= load_word;
		else if (state_q == S_CPY)
			mem[idx_q[AW-1:0]] <= {qy_q, qx_q, qrank_q, bcol_q};
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_we) count_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						idx_q <= entry_index;
						nearest_index <= '0;
						nearest_colour <= '0;
						nearest_sq_distance <= '0;
						if (operation == OP_LOAD) begin
							status <= (32'(entry_index) < MAX_POINTS) ? ST_OK : ST_RANGE;
							out_valid <= 1'b1;
						end else if ({1'b0, entry_index} >= ecount) begin
							status <= ST_RANGE;
							out_valid <= 1'b1;
						end else state_q <= S_QRD;
					end
				end
				S_QRD: state_q <= S_QLAT;
				S_QLAT: begin
					qx_q <= cx;
					qy_q <= cy;
					qrank_q <= crank;
					best_q <= INIT_BEST;
					found_q <= 1'b0;
					bidx_q <= '0;
					dir_q <= 1'b0;
					if (idx_q != '0) begin
						cand_q <= {1'b0, idx_q} - 1'b1;
						state_q <= S_CRD;
					end else if (up_ok) begin
						dir_q <= 1'b1;
						cand_q <= up_start;
						state_q <= S_CRD;
					end else state_q <= S_DONE;
				end
				S_CRD: state_q <= S_CLAT;
				S_CLAT: begin
					sy_s1 <= DW'(ady) * DW'(ady);
					sx_s1 <= DW'(adx) * DW'(adx);
					ok_s1 <= crank < qrank_q;
					ccol_s1 <= ccol;
					state_q <= S_CMP;
				end
				S_CMP: begin
					logic stop;
					stop = 1'b0;
					if (ok_s1) begin
						if (sy_s1 > best_q) stop = 1'b1;
						else if (sx_s1 < best_q && sy_s1 + sx_s1 < best_q) begin
							best_q <= sy_s1 + sx_s1;
							bidx_q <= cand_q[IDX_W-1:0];
							bcol_q <= ccol_s1;
							found_q <= 1'b1;
							nearest_sq_distance <= DIST_W'(sy_s1 + sx_s1);
						end
					end
					if (!stop && nxt_ok) begin
						cand_q <= nxt;
						state_q <= S_CRD;
					end else if (!dir_q && up_ok) begin
						dir_q <= 1'b1;
						cand_q <= up_start;
						state_q <= S_CRD;
					end else state_q <= S_DONE;
				end
				S_DONE: begin
					if (found_q) begin
						state_q <= S_CPY;
					end else begin
						status <= ST_NONE;
						nearest_sq_distance <= '0;
						nearest_colour <= '0;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CPY: begin
					status <= ST_OK;
					nearest_index <= bidx_q;
					nearest_colour <= bcol_q;
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
